// ===== hdl/i2cbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package i2cbm_pkg;

  localparam logic [2:0] MODE_START    = 3'd0;
  localparam logic [2:0] MODE_STOP     = 3'd1;
  localparam logic [2:0] MODE_WRITE    = 3'd2;
  localparam logic [2:0] MODE_READ     = 3'd3;
  localparam logic [2:0] MODE_WAIT_ACK = 3'd4;

  localparam logic CFG_ACK_TIMEOUT = 1'b0;
  localparam logic CFG_PHASE_TICKS = 1'b1;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd100;
  localparam logic [7:0] PHASE_TICKS_RST = 8'd1;
  localparam logic [3:0] LAST_BIT        = 4'd7;

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_ST_A = 16'h0002,
    ST_ST_B = 16'h0004,
    ST_ST_C = 16'h0008,
    ST_SP_A = 16'h0010,
    ST_SP_B = 16'h0020,
    ST_SP_C = 16'h0040,
    ST_WR_D = 16'h0080,
    ST_WR_H = 16'h0100,
    ST_WR_L = 16'h0200,
    ST_RD_L = 16'h0400,
    ST_RD_H = 16'h0800,
    ST_AK_D = 16'h1000,
    ST_AK_H = 16'h2000,
    ST_WA_H = 16'h4000,
    ST_WA_P = 16'h8000
  } step_e;

  typedef struct packed {
    logic       command_valid;
    logic [2:0] mode;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/i2c_bit_level_master.sv =====
// i2c bit level master: one input item per timebase tick, one result item per input item.
// input stream: tuser carries the command flag and mode, tdata the write byte,
// the ack choice for reads and the sampled sda level of the tick.
// output stream: scl and sda levels after the tick, busy, done, last read byte
// and the missing-acknowledge flag.
// config port: index 0 ack_timeout, index 1 phase_ticks, written while idle.
// path: an accepted item passes one input register and then one result register.
// throughput: one item every cycle while the receiver takes results; the sequencer step
// between the two registers is a single pass, so no tick waits on the step of the previous one.
// reset: lines released high, sequencer idle, ack_timeout 100, phase_ticks 1,
// both stages empty.
// when the receiver stalls the result register holds and the input register
// fills; tready drops only when both are full and goes high again in the cycle
// the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module i2c_bit_level_master (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // write_data[7:0], send_ack[8], sda_in[9], zero fill
  input  wire logic [15:0] s_axis_tdata,
  // command_valid[0], mode[3:1]
  input  wire logic [3:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4],
  // ack_missing[12], zero fill
  output logic [15:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i
);
  import i2cbm_pkg::*;

  item_t      in_q;
  logic       in_valid_q;
  res_t       out_q;
  logic       out_valid_q;
  res_t       res;
  logic       step_en;
  logic [7:0] ack_timeout_q;
  logic [7:0] phase_ticks_q;

  assign step_en       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step_en;

  i2cbm_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (step_en),
    .item_i        (in_q),
    .ack_timeout_i (ack_timeout_q),
    .phase_ticks_i (phase_ticks_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= ACK_TIMEOUT_RST;
      phase_ticks_q <= PHASE_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i;
        CFG_PHASE_TICKS: phase_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (step_en) begin
        in_valid_q <= 1'b0;
      end
      if (step_en) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.command_valid <= s_axis_tuser[0];
      in_q.mode          <= s_axis_tuser[3:1];
      in_q.write_data    <= s_axis_tdata[7:0];
      in_q.send_ack      <= s_axis_tdata[8];
      in_q.sda_in        <= s_axis_tdata[9];
    end
    if (step_en) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.ack_missing, out_q.read_data, out_q.done_res,
                          out_q.busy_res, out_q.sda_out, out_q.scl_out};

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
    else $error("done result still reports busy");

  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled without a full pipeline");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step_en |=> in_valid_q && $stable(in_q))
    else $error("stalled input item lost");

endmodule
`default_nettype wire

// ===== hdl/i2cbm_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i2cbm_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire i2cbm_pkg::item_t item_i,
  input  wire logic [7:0]      ack_timeout_i,
  input  wire logic [7:0]      phase_ticks_i,
  output i2cbm_pkg::res_t      res_o
);
  import i2cbm_pkg::*;

  typedef struct packed {
    step_e      step;
    logic [3:0] bits;
    logic [7:0] shift;
    logic [7:0] poll;
    logic [7:0] phase;
    logic       clk_lvl;
    logic       dat_lvl;
    logic       ack_failed;
    logic       pend_ack;
    logic [7:0] last_read;
  } seq_t;

  seq_t seq_q, seq_d;
  logic done;
  logic [7:0] pt;

  function automatic seq_t enter(seq_t s, step_e n, logic sda);
    seq_t r;
    r = s;
    r.step = n;
    r.phase = '0;
    unique case (n)
      ST_ST_A: r.dat_lvl = 1'b1;
      ST_ST_B: r.clk_lvl = 1'b1;
      ST_ST_C: r.dat_lvl = 1'b0;
      ST_SP_A: r.dat_lvl = 1'b0;
      ST_SP_B: r.clk_lvl = 1'b1;
      ST_SP_C: r.dat_lvl = 1'b1;
      ST_WR_D: begin
        r.clk_lvl = 1'b0;
        r.dat_lvl = s.shift[7];
        r.shift   = {s.shift[6:0], 1'b0};
      end
      ST_WR_H: r.clk_lvl = 1'b1;
      ST_WR_L: r.clk_lvl = 1'b0;
      ST_RD_L: r.clk_lvl = 1'b0;
      ST_RD_H: begin
        r.clk_lvl = 1'b1;
        r.shift   = {s.shift[6:0], sda};
      end
      ST_AK_D: begin
        r.last_read = s.shift;
        r.clk_lvl   = 1'b0;
        r.dat_lvl   = ~s.pend_ack;
      end
      ST_AK_H: r.clk_lvl = 1'b1;
      ST_WA_H: begin
        r.dat_lvl = 1'b1;
        r.clk_lvl = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic seq_t advance(seq_t s, logic sda);
    seq_t r;
    r = s;
    unique case (s.step)
      ST_ST_A: r = enter(s, ST_ST_B, sda);
      ST_ST_B: r = enter(s, ST_ST_C, sda);
      ST_ST_C: begin
        r.bits = LAST_BIT;
        r = enter(r, ST_WR_L, sda);
      end
      ST_SP_A: r = enter(s, ST_SP_B, sda);
      ST_SP_B: r = enter(s, ST_SP_C, sda);
      ST_WR_D: r = enter(s, ST_WR_H, sda);
      ST_WR_H: r = enter(s, ST_WR_L, sda);
      ST_WR_L: begin
        r.bits = s.bits + 4'd1;
        r = enter(r, ST_WR_D, sda);
      end
      ST_RD_L: r = enter(s, ST_RD_H, sda);
      ST_RD_H: begin
        if (s.bits < LAST_BIT) begin
          r.bits = s.bits + 4'd1;
          r = enter(r, ST_RD_L, sda);
        end else begin
          r = enter(s, ST_AK_D, sda);
        end
      end
      ST_AK_D: r = enter(s, ST_AK_H, sda);
      ST_AK_H: begin
        r.bits = LAST_BIT;
        r = enter(r, ST_WR_L, sda);
      end
      ST_WA_H: r = enter(s, ST_WA_P, sda);
      default: r.step = ST_IDLE;
    endcase
    return r;
  endfunction

  always_comb begin
    pt    = (phase_ticks_i == 8'd0) ? 8'd1 : phase_ticks_i;
    done  = 1'b0;
    seq_d = seq_q;

    if (seq_d.step == ST_IDLE) begin
      if (item_i.command_valid) begin
        unique case (item_i.mode)
          MODE_START: seq_d = enter(seq_d, ST_ST_A, item_i.sda_in);
          MODE_STOP:  seq_d = enter(seq_d, ST_SP_A, item_i.sda_in);
          MODE_WRITE: begin
            seq_d.shift = item_i.write_data;
            seq_d.bits  = '0;
            seq_d = enter(seq_d, ST_WR_D, item_i.sda_in);
          end
          MODE_READ: begin
            seq_d.pend_ack = item_i.send_ack;
            seq_d.shift    = '0;
            seq_d.bits     = '0;
            seq_d.dat_lvl  = 1'b1;
            seq_d = enter(seq_d, ST_RD_L, item_i.sda_in);
          end
          MODE_WAIT_ACK: begin
            seq_d.ack_failed = 1'b0;
            seq_d.poll       = '0;
            seq_d = enter(seq_d, ST_WA_H, item_i.sda_in);
          end
          default: ;
        endcase
      end
    end else if (seq_d.step != ST_WA_P && seq_d.phase >= pt) begin
      seq_d = advance(seq_d, item_i.sda_in);
    end

    if (seq_d.step == ST_WA_P) begin
      if (!item_i.sda_in) begin
        seq_d.clk_lvl = 1'b0;
        seq_d.step    = ST_IDLE;
        done          = 1'b1;
      end else if (seq_d.poll >= ack_timeout_i) begin
        seq_d.ack_failed = 1'b1;
        seq_d = enter(seq_d, ST_SP_A, item_i.sda_in);
      end else begin
        seq_d.poll = seq_d.poll + 8'd1;
      end
    end

    if (seq_d.step != ST_IDLE && seq_d.step != ST_WA_P) begin
      seq_d.phase = seq_d.phase + 8'd1;
      if (seq_d.phase >= pt && (seq_d.step == ST_SP_C ||
          (seq_d.step == ST_WR_L && seq_d.bits >= LAST_BIT))) begin
        seq_d.step  = ST_IDLE;
        seq_d.phase = '0;
        done        = 1'b1;
      end
    end

    res_o.scl_out     = seq_d.clk_lvl;
    res_o.sda_out     = seq_d.dat_lvl;
    res_o.busy_res    = (seq_d.step != ST_IDLE);
    res_o.done_res    = done;
    res_o.read_data   = seq_d.last_read;
    res_o.ack_missing = seq_d.ack_failed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q.step       <= ST_IDLE;
      seq_q.bits       <= '0;
      seq_q.shift      <= '0;
      seq_q.poll       <= '0;
      seq_q.phase      <= '0;
      seq_q.clk_lvl    <= 1'b1;
      seq_q.dat_lvl    <= 1'b1;
      seq_q.ack_failed <= 1'b0;
      seq_q.pend_ack   <= 1'b0;
      seq_q.last_read  <= '0;
    end else if (en_i) begin
      seq_q <= seq_d;
    end
  end

endmodule
`default_nettype wire

// ===== bench/i2cbm_checker.sv =====
`timescale 1ns / 1ps
module i2cbm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // write_data[7:0], send_ack[8], sda_in[9], zero fill
  input  logic [15:0] s_axis_tdata,
  // command_valid[0], mode[3:1]
  input  logic [3:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4],
  // ack_missing[12], zero fill
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output int          mismatch_cnt_o,
  output int          pending_o,
  output int          ticks_seen_o,
  output logic        seq_busy_o
);
  import i2cbm_pkg::*;

  res_t       line_levels_q[$];
  step_e      seq_step;
  logic [3:0] bit_cnt;
  logic [7:0] shreg;
  logic [7:0] polls;
  logic [7:0] phase_cnt;
  logic       scl_lvl;
  logic       sda_lvl;
  logic       ack_fail;
  logic       ack_choice;
  logic [7:0] last_byte;
  logic [7:0] cfg_timeout;
  logic [7:0] cfg_ticks;
  int         mism;
  int         seen;
  res_t       got;
  res_t       want;
  item_t      tick_in;

  function automatic void enter_step(step_e nxt, logic smp);
    seq_step  = nxt;
    phase_cnt = 8'd0;
    case (nxt)
      ST_ST_A: sda_lvl = 1'b1;
      ST_ST_B: scl_lvl = 1'b1;
      ST_ST_C: sda_lvl = 1'b0;
      ST_SP_A: sda_lvl = 1'b0;
      ST_SP_B: scl_lvl = 1'b1;
      ST_SP_C: sda_lvl = 1'b1;
      ST_WR_D: begin
        scl_lvl = 1'b0;
        sda_lvl = shreg[7];
        shreg   = {shreg[6:0], 1'b0};
      end
      ST_WR_H: scl_lvl = 1'b1;
      ST_WR_L: scl_lvl = 1'b0;
      ST_RD_L: scl_lvl = 1'b0;
      ST_RD_H: begin
        scl_lvl = 1'b1;
        shreg   = {shreg[6:0], smp};
      end
      ST_AK_D: begin
        last_byte = shreg;
        scl_lvl   = 1'b0;
        sda_lvl   = ~ack_choice;
      end
      ST_AK_H: scl_lvl = 1'b1;
      ST_WA_H: begin
        sda_lvl = 1'b1;
        scl_lvl = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void next_phase(logic smp);
    case (seq_step)
      ST_ST_A: enter_step(ST_ST_B, smp);
      ST_ST_B: enter_step(ST_ST_C, smp);
      ST_ST_C: begin
        bit_cnt = LAST_BIT;
        enter_step(ST_WR_L, smp);
      end
      ST_SP_A: enter_step(ST_SP_B, smp);
      ST_SP_B: enter_step(ST_SP_C, smp);
      ST_WR_D: enter_step(ST_WR_H, smp);
      ST_WR_H: enter_step(ST_WR_L, smp);
      ST_WR_L: begin
        bit_cnt = bit_cnt + 4'd1;
        enter_step(ST_WR_D, smp);
      end
      ST_RD_L: enter_step(ST_RD_H, smp);
      ST_RD_H: begin
        if (bit_cnt < LAST_BIT) begin
          bit_cnt = bit_cnt + 4'd1;
          enter_step(ST_RD_L, smp);
        end else begin
          enter_step(ST_AK_D, smp);
        end
      end
      ST_AK_D: enter_step(ST_AK_H, smp);
      ST_AK_H: begin
        bit_cnt = LAST_BIT;
        enter_step(ST_WR_L, smp);
      end
      ST_WA_H: enter_step(ST_WA_P, smp);
      default: seq_step = ST_IDLE;
    endcase
  endfunction

  // one timebase tick of the line sequencer
  function automatic res_t line_tick(item_t it);
    logic [7:0] pt;
    logic       done;
    res_t       r;
    pt   = (cfg_ticks == 8'd0) ? 8'd1 : cfg_ticks;
    done = 1'b0;
    if (seq_step == ST_IDLE) begin
      if (it.command_valid && it.mode <= MODE_WAIT_ACK) begin
        case (it.mode)
          MODE_START: enter_step(ST_ST_A, it.sda_in);
          MODE_STOP:  enter_step(ST_SP_A, it.sda_in);
          MODE_WRITE: begin
            shreg   = it.write_data;
            bit_cnt = 4'd0;
            enter_step(ST_WR_D, it.sda_in);
          end
          MODE_READ: begin
            ack_choice = it.send_ack;
            shreg      = 8'd0;
            bit_cnt    = 4'd0;
            sda_lvl    = 1'b1;
            enter_step(ST_RD_L, it.sda_in);
          end
          default: begin
            ack_fail = 1'b0;
            polls    = 8'd0;
            enter_step(ST_WA_H, it.sda_in);
          end
        endcase
      end
    end else if (seq_step != ST_WA_P && phase_cnt >= pt) begin
      next_phase(it.sda_in);
    end
    if (seq_step == ST_WA_P) begin
      if (!it.sda_in) begin
        scl_lvl  = 1'b0;
        seq_step = ST_IDLE;
        done     = 1'b1;
      end else if (polls >= cfg_timeout) begin
        ack_fail = 1'b1;
        enter_step(ST_SP_A, it.sda_in);
      end else begin
        polls = polls + 8'd1;
      end
    end
    if (seq_step != ST_IDLE && seq_step != ST_WA_P) begin
      phase_cnt = phase_cnt + 8'd1;
      if (phase_cnt >= pt &&
          (seq_step == ST_SP_C || (seq_step == ST_WR_L && bit_cnt >= LAST_BIT))) begin
        seq_step  = ST_IDLE;
        phase_cnt = 8'd0;
        done      = 1'b1;
      end
    end
    r.scl_out     = scl_lvl;
    r.sda_out     = sda_lvl;
    r.busy_res    = (seq_step != ST_IDLE);
    r.done_res    = done;
    r.read_data   = last_byte;
    r.ack_missing = ack_fail;
    return r;
  endfunction

  function automatic void report(string what, res_t exp_r, res_t act_r);
    mism++;
    if (mism <= 10) begin
      $display("%s: scl %0b/%0b sda %0b/%0b busy %0b/%0b done %0b/%0b",
               what, exp_r.scl_out, act_r.scl_out, exp_r.sda_out, act_r.sda_out,
               exp_r.busy_res, act_r.busy_res, exp_r.done_res, act_r.done_res);
      $display("  read %02h/%02h ack_missing %0b/%0b (expected/actual)",
               exp_r.read_data, act_r.read_data, exp_r.ack_missing, act_r.ack_missing);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_levels_q.delete();
      seq_step    = ST_IDLE;
      bit_cnt     = 4'd0;
      shreg       = 8'd0;
      polls       = 8'd0;
      phase_cnt   = 8'd0;
      scl_lvl     = 1'b1;
      sda_lvl     = 1'b1;
      ack_fail    = 1'b0;
      ack_choice  = 1'b0;
      last_byte   = 8'd0;
      cfg_timeout = ACK_TIMEOUT_RST;
      cfg_ticks   = PHASE_TICKS_RST;
      mism        = 0;
      seen        = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
      ticks_seen_o   <= 0;
      seq_busy_o     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ACK_TIMEOUT) begin
          cfg_timeout = cfg_data_i;
        end else begin
          cfg_ticks = cfg_data_i;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.scl_out     = m_axis_tdata[0];
        got.sda_out     = m_axis_tdata[1];
        got.busy_res    = m_axis_tdata[2];
        got.done_res    = m_axis_tdata[3];
        got.read_data   = m_axis_tdata[11:4];
        got.ack_missing = m_axis_tdata[12];
        if (line_levels_q.size() == 0) begin
          report("item with none pending", '0, got);
        end else begin
          want = line_levels_q.pop_front();
          if (got !== want) begin
            report("line level mismatch", want, got);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tick_in.command_valid = s_axis_tuser[0];
        tick_in.mode          = s_axis_tuser[3:1];
        tick_in.write_data    = s_axis_tdata[7:0];
        tick_in.send_ack      = s_axis_tdata[8];
        tick_in.sda_in        = s_axis_tdata[9];
        line_levels_q.push_back(line_tick(tick_in));
        seen++;
      end
      mismatch_cnt_o <= mism;
      pending_o      <= line_levels_q.size();
      ticks_seen_o   <= seen;
      seq_busy_o     <= (seq_step != ST_IDLE);
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import i2cbm_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // write_data[7:0], send_ack[8], sda_in[9], zero fill
  logic [15:0] s_axis_tdata = '0;
  // command_valid[0], mode[3:1]
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4],
  // ack_missing[12], zero fill
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [7:0]  cfg_data_i = '0;

  int   mismatches;
  int   pending;
  int   ticks_seen;
  logic seq_busy;
  int   pushed = 0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   sda_low_pct = 50;
  int   quiet_cycles = 0;

  i2c_bit_level_master dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  i2cbm_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending),
    .ticks_seen_o   (ticks_seen),
    .seq_busy_o     (seq_busy)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic push_tick(input logic cmd, input logic [2:0] mode,
                           input logic [7:0] wdata, input logic ack);
    logic sda_bit;
    sda_bit = ($urandom_range(99) < sda_low_pct) ? 1'b0 : 1'b1;
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {mode, cmd};
    s_axis_tdata  <= {6'b0, sda_bit, ack, wdata};
    do @(posedge clk_i); while (!s_axis_tready);
    pushed++;
    wait (ticks_seen == pushed);
  endtask

  // plain ticks until the sequencer goes back to idle
  task automatic drain();
    while (seq_busy) begin
      push_tick(1'b0, 3'($urandom_range(7)), 8'($urandom_range(255)),
                1'($urandom_range(1)));
    end
  endtask

  task automatic run_cmd(input logic [2:0] mode, input logic [7:0] wdata,
                         input logic ack);
    push_tick(1'b1, mode, wdata, ack);
    drain();
  endtask

  task automatic set_cfg(input logic [7:0] tmo, input logic [7:0] ticks);
    drain();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ACK_TIMEOUT;
    cfg_data_i <= tmo;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PHASE_TICKS;
    cfg_data_i <= ticks;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic random_phase(input logic [7:0] tmo, input logic [7:0] ticks,
                              input int src_pct, input int sink_pct,
                              input int low_pct, input int n);
    logic [2:0] mode;
    set_cfg(tmo, ticks);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sda_low_pct    = low_pct;
    repeat (n) begin
      if ($urandom_range(99) < 6) begin
        mode = MODE_WAIT_ACK + 3'd1 + 3'($urandom_range(2));
      end else begin
        mode = 3'($urandom_range(MODE_WAIT_ACK));
      end
      push_tick($urandom_range(99) < 40, mode, 8'($urandom_range(255)),
                1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_cmd(MODE_START, 8'h00, 1'b0);
    run_cmd(MODE_WRITE, 8'h00, 1'b0);
    run_cmd(MODE_WRITE, 8'hFF, 1'b1);
    run_cmd(MODE_WRITE, 8'hA5, 1'b0);
    run_cmd(MODE_READ, 8'h5A, 1'b1);
    run_cmd(MODE_READ, 8'h00, 1'b0);
    sda_low_pct = 100;
    run_cmd(MODE_WAIT_ACK, 8'h00, 1'b0);
    sda_low_pct = 2;
    run_cmd(MODE_WAIT_ACK, 8'h00, 1'b0);
    sda_low_pct = 50;
    run_cmd(MODE_STOP, 8'h00, 1'b0);
    // unused modes start nothing
    for (int m = MODE_WAIT_ACK + 1; m <= 7; m++) begin
      push_tick(1'b1, 3'(m), 8'hFF, 1'b1);
    end
    // start offered while a write runs is ignored
    push_tick(1'b1, MODE_WRITE, 8'h81, 1'b0);
    run_cmd(MODE_START, 8'h00, 1'b0);

    // zero timeout and zero phase length
    set_cfg(8'd0, 8'd0);
    sda_low_pct = 0;
    run_cmd(MODE_WAIT_ACK, 8'h00, 1'b0);
    sda_low_pct = 50;
    run_cmd(MODE_WRITE, 8'h3C, 1'b0);
    run_cmd(MODE_READ, 8'hC3, 1'b1);

    set_cfg(8'd255, 8'd1);
    sda_low_pct = 0;
    run_cmd(MODE_WAIT_ACK, 8'h00, 1'b0);

    set_cfg(8'd1, 8'd20);
    sda_low_pct = 50;
    run_cmd(MODE_STOP, 8'h00, 1'b0);

    random_phase(8'd1, 8'd1, 0, 0, 20, 130);
    random_phase(8'd3, 8'd2, 85, 0, 25, 130);
    random_phase(8'd12, 8'd1, 0, 85, 15, 130);
    random_phase(8'd100, 8'd3, 16, 16, 40, 130);

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
